// File: src/sgd_pkg.sv
// Shared types and constants for the sedentary get-up detector.
// No dependencies; used by every module under src.
`timescale 1ns / 1ps

package sgd_pkg;

    // Register indexes on the configuration port
    localparam int unsigned CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE         = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ALARM_SECONDS  = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_HIGH      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BAND_LOW       = 4'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PEAK_FLOOR     = 4'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_VALLEY_CEILING = 4'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_DROP_MIN       = 4'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_INDEX_WINDOW   = 4'd7;

    // Register reset values
    localparam logic [13:0] ALARM_SECONDS_RST  = 14'd300;
    localparam logic [15:0] BAND_HIGH_RST      = 16'd120;
    localparam logic [15:0] BAND_LOW_RST       = 16'd80;
    localparam logic [15:0] PEAK_FLOOR_RST     = 16'd130;
    localparam logic [15:0] VALLEY_CEILING_RST = 16'd70;
    localparam logic [15:0] DROP_MIN_RST       = 16'd40;
    localparam logic [31:0] INDEX_WINDOW_RST   = 32'd50;

    // Tracker start value for the previous magnitude
    localparam logic [15:0] PREV_MAG_RST = 16'd100;

    // Divide by 100: sums at or above 100 * 65536 saturate, the rest fit in
    // 23 bits and use a reciprocal multiply, floor(s * ceil(2^30/100) / 2^30)
    localparam logic [31:0] SUM_SAT_LIMIT = 32'd6553600;
    localparam int unsigned SUM_LOW_W     = 23;
    localparam int unsigned RECIP_W       = 24;
    localparam int unsigned RECIP_SHIFT   = 30;
    localparam logic [RECIP_W-1:0] RECIP_100 = 24'd10737419;
    localparam int unsigned PROD_W        = SUM_LOW_W + RECIP_W;

    typedef struct packed {
        logic        enable;
        logic [13:0] alarm_seconds;
        logic [15:0] band_high;
        logic [15:0] band_low;
        logic [15:0] peak_floor;
        logic [15:0] valley_ceiling;
        logic [15:0] drop_min;
        logic [31:0] index_window;
    } cfg_t;

    // One sample after the magnitude stages
    typedef struct packed {
        logic [15:0] magnitude;
        logic [31:0] sample_index;
        logic [31:0] now_seconds;
    } mag_item_t;

    // Tracker status seen by the top level
    typedef struct packed {
        logic take;
        logic armed;
        logic falling;
        logic peak_valid;
    } trk_status_t;

endpackage

// File: src/sgd_mag.sv
// Magnitude pipeline: input register, sum of squares, divide by 100 with saturation.
// Depends on sgd_pkg.
`timescale 1ns / 1ps

module sgd_mag (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic [31:0]        sample_index,
    input  logic [31:0]        now_seconds,
    output logic               out_valid,
    input  logic               out_ready,
    output sgd_pkg::mag_item_t out_item
);

    logic               v1_reg, v2_reg, v3_reg;
    logic               rdy1, rdy2, rdy3;

    logic signed [15:0] x_reg, y_reg, z_reg;
    logic [31:0]        idx1_reg, now1_reg;

    logic                             sat2_reg;
    logic [sgd_pkg::SUM_LOW_W-1:0]    sum2_reg;
    logic [31:0]                      idx2_reg, now2_reg;

    sgd_pkg::mag_item_t item3_reg;

    logic signed [31:0]             sq_x, sq_y, sq_z;
    logic [31:0]                    sum_next;
    logic [sgd_pkg::PROD_W-1:0]     prod;
    logic [15:0]                    mag_next;

    // Each stage loads when empty or when the stage after it moves on
    assign rdy3     = !v3_reg || out_ready;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // Squares are non-negative and at most 2^30 each, so the sum fits 32 bits
    assign sq_x     = x_reg * x_reg;
    assign sq_y     = y_reg * y_reg;
    assign sq_z     = z_reg * z_reg;
    assign sum_next = $unsigned(sq_x) + $unsigned(sq_y) + $unsigned(sq_z);

    assign prod     = {{sgd_pkg::RECIP_W{1'b0}}, sum2_reg}
                    * {{sgd_pkg::SUM_LOW_W{1'b0}}, sgd_pkg::RECIP_100};
    assign mag_next = sat2_reg ? 16'hFFFF
                               : prod[sgd_pkg::RECIP_SHIFT +: 16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
            if (rdy3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && rdy1) begin
            x_reg    <= accel_x;
            y_reg    <= accel_y;
            z_reg    <= accel_z;
            idx1_reg <= sample_index;
            now1_reg <= now_seconds;
        end
        if (v1_reg && rdy2) begin
            sat2_reg <= (sum_next >= sgd_pkg::SUM_SAT_LIMIT);
            sum2_reg <= sum_next[sgd_pkg::SUM_LOW_W-1:0];
            idx2_reg <= idx1_reg;
            now2_reg <= now1_reg;
        end
        if (v2_reg && rdy3) begin
            item3_reg.magnitude    <= mag_next;
            item3_reg.sample_index <= idx2_reg;
            item3_reg.now_seconds  <= now2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule

// File: src/sgd_tracker.sv
// Turning-point tracker, sitting timer and result register.
// Depends on sgd_pkg.
`timescale 1ns / 1ps

module sgd_tracker (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  sgd_pkg::cfg_t         cfg,
    input  logic                  clear,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  sgd_pkg::mag_item_t    in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [15:0]           out_magnitude,
    output logic                  out_getup,
    output logic                  out_alarm,
    output sgd_pkg::trk_status_t  status
);

    logic [15:0] prev_mag_reg,   prev_mag_next;
    logic        falling_reg,    falling_next;
    logic        peak_valid_reg, peak_valid_next;
    logic [15:0] peak_value_reg, peak_value_next;
    logic [31:0] peak_index_reg, peak_index_next;
    logic [31:0] sit_start_reg,  sit_start_next;
    logic        armed_reg,      armed_next;

    logic        out_valid_reg;
    logic [15:0] mag_reg;
    logic        getup_reg, getup_next;
    logic        alarm_reg, alarm_next;

    logic        take;
    logic [15:0] mag;
    logic [31:0] idx, now;
    logic [31:0] start;
    logic        feed, valley_ok;
    logic [31:0] idx_gap, elapsed;
    logic [15:0] drop;

    assign in_ready = !out_valid_reg || out_ready;
    assign take     = in_valid && in_ready;

    assign mag = in_item.magnitude;
    assign idx = in_item.sample_index;
    assign now = in_item.now_seconds;

    assign feed      = (mag > cfg.band_high) || (mag < cfg.band_low);
    assign drop      = peak_value_reg - prev_mag_reg;
    assign idx_gap   = idx - peak_index_reg;
    assign valley_ok = (prev_mag_reg < cfg.valley_ceiling) && peak_valid_reg
                    && (peak_value_reg > prev_mag_reg) && (drop > cfg.drop_min)
                    && (idx_gap < cfg.index_window);

    always_comb begin
        prev_mag_next   = prev_mag_reg;
        falling_next    = falling_reg;
        peak_valid_next = peak_valid_reg;
        peak_value_next = peak_value_reg;
        peak_index_next = peak_index_reg;
        armed_next      = armed_reg;
        getup_next      = 1'b0;
        alarm_next      = 1'b0;
        start           = armed_reg ? sit_start_reg : now;
        elapsed         = 32'd0;

        if (cfg.enable) begin
            armed_next = 1'b1;
            if (feed) begin
                prev_mag_next = mag;
                if (mag > prev_mag_reg) begin
                    if (falling_reg) begin
                        falling_next = 1'b0;
                        if (valley_ok) begin
                            getup_next = 1'b1;
                            start      = now;
                        end
                    end
                end else if (!falling_reg) begin
                    falling_next = 1'b1;
                    if (prev_mag_reg > cfg.peak_floor) begin
                        peak_valid_next = 1'b1;
                        peak_index_next = idx;
                        peak_value_next = prev_mag_reg;
                    end
                end
            end
            elapsed = now - start;
            if (elapsed >= {18'd0, cfg.alarm_seconds}) begin
                alarm_next = 1'b1;
                start      = now;
            end
        end
        sit_start_next = cfg.enable ? start : sit_start_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || clear) begin
            prev_mag_reg   <= sgd_pkg::PREV_MAG_RST;
            falling_reg    <= 1'b0;
            peak_valid_reg <= 1'b0;
            peak_value_reg <= 16'd0;
            peak_index_reg <= 32'd0;
            armed_reg      <= 1'b0;
        end else if (take) begin
            prev_mag_reg   <= prev_mag_next;
            falling_reg    <= falling_next;
            peak_valid_reg <= peak_valid_next;
            peak_value_reg <= peak_value_next;
            peak_index_reg <= peak_index_next;
            armed_reg      <= armed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sit_start_reg <= 32'd0;
        end else if (take) begin
            sit_start_reg <= sit_start_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (in_ready) begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            mag_reg   <= mag;
            getup_reg <= getup_next;
            alarm_reg <= alarm_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign out_magnitude = mag_reg;
    assign out_getup     = getup_reg;
    assign out_alarm     = alarm_reg;

    assign status.take       = take;
    assign status.armed      = armed_reg;
    assign status.falling    = falling_reg;
    assign status.peak_valid = peak_valid_reg;

endmodule

// File: src/sedentary_getup_detector_unit.sv
// Top level of the sedentary get-up detector: configuration registers,
// magnitude pipeline and tracker. Depends on sgd_pkg, sgd_mag, sgd_tracker.
`timescale 1ns / 1ps

// One accelerometer sample is accepted per cycle, sustained while m_tready is
// high, and its result passes through the input register, sum of squares,
// divide by 100 and tracker result register to the master side. The tracker
// updates its peak, valley and timer state once per sample. Back pressure on
// the master side fills the four stages before s_tready drops. Write the
// configuration only while no sample is in flight; writing 0 to enable clears
// the tracker and disarms the timer.

module sedentary_getup_detector_unit (
    input  logic         aclk,
    input  logic         aresetn,
    // accel_x[15:0], accel_y[31:16], accel_z[47:32],
    // sample_index[79:48], now_seconds[111:80]
    input  logic [111:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // magnitude[15:0], getup_seen[16], sit_alarm[17], zero fill [23:18]
    output logic [23:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_wr_en,
    input  logic [3:0]   cfg_wr_index,
    input  logic [31:0]  cfg_wr_data
);

    sgd_pkg::cfg_t        cfg_reg;
    sgd_pkg::mag_item_t   mag_item;
    sgd_pkg::trk_status_t trk_status;

    logic        mag_valid, mag_ready;
    logic        trk_clear;
    logic [15:0] magnitude;
    logic        getup_seen, sit_alarm;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.enable         <= 1'b0;
            cfg_reg.alarm_seconds  <= sgd_pkg::ALARM_SECONDS_RST;
            cfg_reg.band_high      <= sgd_pkg::BAND_HIGH_RST;
            cfg_reg.band_low       <= sgd_pkg::BAND_LOW_RST;
            cfg_reg.peak_floor     <= sgd_pkg::PEAK_FLOOR_RST;
            cfg_reg.valley_ceiling <= sgd_pkg::VALLEY_CEILING_RST;
            cfg_reg.drop_min       <= sgd_pkg::DROP_MIN_RST;
            cfg_reg.index_window   <= sgd_pkg::INDEX_WINDOW_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                sgd_pkg::REG_ENABLE:         cfg_reg.enable         <= cfg_wr_data[0];
                sgd_pkg::REG_ALARM_SECONDS:  cfg_reg.alarm_seconds  <= cfg_wr_data[13:0];
                sgd_pkg::REG_BAND_HIGH:      cfg_reg.band_high      <= cfg_wr_data[15:0];
                sgd_pkg::REG_BAND_LOW:       cfg_reg.band_low       <= cfg_wr_data[15:0];
                sgd_pkg::REG_PEAK_FLOOR:     cfg_reg.peak_floor     <= cfg_wr_data[15:0];
                sgd_pkg::REG_VALLEY_CEILING: cfg_reg.valley_ceiling <= cfg_wr_data[15:0];
                sgd_pkg::REG_DROP_MIN:       cfg_reg.drop_min       <= cfg_wr_data[15:0];
                sgd_pkg::REG_INDEX_WINDOW:   cfg_reg.index_window   <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // Dropping enable wipes the tracker in the same edge
    assign trk_clear = cfg_wr_en && (cfg_wr_index == sgd_pkg::REG_ENABLE) && !cfg_wr_data[0];

    sgd_mag u_mag (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .accel_x      ($signed(s_tdata[15:0])),
        .accel_y      ($signed(s_tdata[31:16])),
        .accel_z      ($signed(s_tdata[47:32])),
        .sample_index (s_tdata[79:48]),
        .now_seconds  (s_tdata[111:80]),
        .out_valid    (mag_valid),
        .out_ready    (mag_ready),
        .out_item     (mag_item)
    );

    sgd_tracker u_tracker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .clear         (trk_clear),
        .in_valid      (mag_valid),
        .in_ready      (mag_ready),
        .in_item       (mag_item),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_magnitude (magnitude),
        .out_getup     (getup_seen),
        .out_alarm     (sit_alarm),
        .status        (trk_status)
    );

    assign m_tdata = {6'd0, sit_alarm, getup_seen, magnitude};

    // The timer is armed only while detection is on
    a_armed_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        trk_status.armed |-> cfg_reg.enable)
        else $error("timer armed while detection is off");

    // Arming happens only on a sample entering the tracker
    a_arm_on_take: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(trk_status.armed) |-> $past(trk_status.take))
        else $error("timer armed without a sample");

    // A recorded peak survives until the tracker is cleared
    a_peak_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        (trk_status.peak_valid && !trk_clear) |=> trk_status.peak_valid)
        else $error("peak lost without a clear");

    // A falling edge is only followed once the timer has been armed
    a_falling_needs_arm: assert property (@(posedge aclk) disable iff (!aresetn)
        trk_status.falling |-> trk_status.armed)
        else $error("tracker falling while the timer is not armed");

endmodule
